/* rtl/pfcc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the pressure frame converter.
package pfcc_pkg;

    typedef enum logic [1:0] {
        CMD_MEASURE      = 2'd0,
        CMD_CAL_START    = 2'd1,
        CMD_CAL_FINISH   = 2'd2,
        CMD_LOAD_DEFAULT = 2'd3
    } cmd_code_t;

    localparam logic [1:0] REG_PMIN           = 2'd0;
    localparam logic [1:0] REG_PMAX           = 2'd1;
    localparam logic [1:0] REG_DEFAULT_OFFSET = 2'd2;

    localparam logic [2:0] STATUS_NORMAL    = 3'd0;
    localparam logic [2:0] STATUS_STALE     = 3'd2;
    localparam logic [2:0] STATUS_BUS_FAULT = 3'd4;

    localparam int FRAME_W    = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_DATA_W = 16;

    localparam logic [9:0]  PMAX_RESET      = 10'd100;
    localparam logic [7:0]  MAX_CAL_SAMPLES = 8'd255;

    // Exact divide by 140 for magnitudes below 2**25: (m * RECIP_140) >> 32
    localparam logic [24:0] RECIP_140       = 25'd30678338;

    // Restoring divider geometry
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;
    localparam int DIVISOR_W  = 14;
    localparam int QUOT_W     = 25;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic div_start;
        logic post;
        logic write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic meas_path;
        logic avg_path;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/pressure_frame_convert_calibrate.sv */
`timescale 1ns / 1ps
// Top level: pressure frame conversion with zero-offset calibration.
//
//  channel  | signals                         | content
//  ---------+---------------------------------+---------------------------------------
//  s_axis   | tvalid tready tdata[31:0] tuser | frame; tuser = cmd, bus_fault
//  m_axis   | tvalid tready tdata[79:0]       | one reading per transaction
//  cfg      | valid ready index[1:0] data     | 0 pmin_psi, 1 pmax_psi, 2 default offset
//
// A good measure frame passes capture, span product, reciprocal divide by 140, offset and
// clamp, and write before it is valid on m_axis. Finish with samples runs the 32-step
// divider for the average; other commands and fault frames skip the arithmetic and go
// straight to the write. One item is in work at a time; the next is taken the cycle
// after the write, also while the last result waits in the output register, and a full
// output register stalls the write. Reset clears offset, calibration, pmin and the
// default offset and sets pmax to 100; cfg is always ready.
module pressure_frame_convert_calibrate (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pfcc_pkg::FRAME_W-1:0]        s_axis_tdata,   // frame[31:0]
    input  logic [pfcc_pkg::IN_USER_W-1:0]      s_axis_tuser,   // cmd[1:0], bus_fault[2]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[2:0], ok[3], pres_counts[17:4], temp_counts[28:18],
    // pres_centi_psi[44:29], temperature_cdeg[56:45], offset_now[72:57], zero[79:73]
    output logic [pfcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [pfcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pfcc_pkg::ctrl_cmd_t  ctl;
    pfcc_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    pfcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    pfcc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_in    (s_axis_tuser[1:0]),
        .frame_in  (s_axis_tdata),
        .fault_in  (s_axis_tuser[2]),
        .ctl       (ctl),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/pfcc_div.sv */
`timescale 1ns / 1ps
// Sequential signed-by-unsigned restoring divider, one quotient bit per cycle.
module pfcc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [31:0]                  dividend,
    input  logic [pfcc_pkg::DIVISOR_W-1:0]      divisor,
    output logic signed [pfcc_pkg::QUOT_W-1:0]  quotient,
    output logic                                done
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [pfcc_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                              neg_reg;
    logic [31:0]                       dvd_reg;
    logic [pfcc_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [pfcc_pkg::DIVISOR_W-1:0]    dsr_reg;

    logic [pfcc_pkg::DIVISOR_W:0]      shifted;
    logic [pfcc_pkg::DIVISOR_W:0]      trial;
    logic                              fits;
    logic [pfcc_pkg::QUOT_W-1:0]       q_mag;

    assign shifted = {rem_reg, dvd_reg[31]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};
    assign q_mag   = dvd_reg[pfcc_pkg::QUOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == pfcc_pkg::DIV_CNT_W'(pfcc_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // Work on magnitudes; the sign goes back on at the end
            neg_reg <= dividend[31];
            dvd_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], fits};
            rem_reg <= fits ? trial[pfcc_pkg::DIVISOR_W-1:0]
                            : shifted[pfcc_pkg::DIVISOR_W-1:0];
        end
    end

    assign quotient = $signed(neg_reg ? (pfcc_pkg::QUOT_W'(0) - q_mag) : q_mag);
    assign done     = done_reg;

endmodule

/* rtl/pfcc_dp.sv */
`timescale 1ns / 1ps
// Datapath: settings, captured item, scaling multipliers, offset and calibration state.
module pfcc_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr,
    input  logic [1:0]                           cfg_index,
    input  logic [pfcc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [1:0]                           cmd_in,
    input  logic [pfcc_pkg::FRAME_W-1:0]         frame_in,
    input  logic                                 fault_in,
    input  pfcc_pkg::ctrl_cmd_t                  ctl,
    output pfcc_pkg::dp_status_t                 sts,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [pfcc_pkg::OUT_DATA_W-1:0]      out_data
);

    // Settings
    logic signed [7:0]  pmin_reg;
    logic [9:0]         pmax_reg;
    logic signed [15:0] dflt_reg;

    // Captured item
    pfcc_pkg::cmd_code_t          c_cmd_reg;
    logic [pfcc_pkg::FRAME_W-1:0] c_frame_reg;
    logic                         c_fault_reg;

    // Arithmetic pipeline
    logic signed [26:0] prod1_reg;
    logic [49:0]        prod2_reg;
    logic               p_neg_reg;
    logic signed [15:0] post_val_reg;

    // Offset and calibration state
    logic signed [15:0] zero_reg,  zero_next;
    logic signed [15:0] saved_reg, saved_next;
    logic signed [23:0] sum_reg,   sum_next;
    logic [7:0]         cnt_reg,   cnt_next;
    logic               cal_reg,   cal_next;

    // Output register
    logic                                out_valid_reg;
    logic [pfcc_pkg::OUT_DATA_W-1:0]     out_data_reg;

    logic [1:0]         status_raw;
    logic [13:0]        rawp;
    logic [10:0]        rawt;
    logic               is_measure;
    logic               meas_good;
    logic               ok;
    logic signed [14:0] diff;
    logic signed [11:0] span;
    logic signed [26:0] diff_w;
    logic signed [26:0] span_w;
    logic [26:0]        prod1_mag;
    logic [17:0]        q_meas_mag;
    logic signed [25:0] q_meas;
    logic signed [31:0] div_dividend;
    logic [pfcc_pkg::DIVISOR_W-1:0] div_divisor;
    logic signed [pfcc_pkg::QUOT_W-1:0] quot;
    logic               div_done;
    logic signed [25:0] pmin_w;
    logic signed [25:0] zero_w;
    logic signed [25:0] p_sum;
    logic signed [15:0] p_sat;
    logic signed [15:0] avg_sel;
    logic [21:0]        t_scaled;
    logic [11:0]        tcdeg;
    logic [2:0]         o_status;
    logic               out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg <= '0;
            pmax_reg <= pfcc_pkg::PMAX_RESET;
            dflt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                pfcc_pkg::REG_PMIN:           pmin_reg <= cfg_data[7:0];
                pfcc_pkg::REG_PMAX:           pmax_reg <= cfg_data[9:0];
                pfcc_pkg::REG_DEFAULT_OFFSET: dflt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            c_cmd_reg   <= pfcc_pkg::cmd_code_t'(cmd_in);
            c_frame_reg <= frame_in;
            c_fault_reg <= fault_in;
        end
        if (ctl.mul1)
        begin
            prod1_reg <= diff_w * span_w;
        end
        if (ctl.mul2)
        begin
            prod2_reg <= 50'(prod1_mag[24:0]) * 50'(pfcc_pkg::RECIP_140);
            p_neg_reg <= prod1_reg[26];
        end
        if (ctl.post)
        begin
            post_val_reg <= is_measure ? p_sat : avg_sel;
        end
    end

    // Frame fields
    assign status_raw = c_frame_reg[31:30];
    assign rawp       = c_frame_reg[29:16];
    assign rawt       = c_frame_reg[15:5];
    assign is_measure = (c_cmd_reg == pfcc_pkg::CMD_MEASURE);
    assign meas_good  = is_measure && !c_fault_reg;
    assign ok = meas_good && (({1'b0, status_raw} == pfcc_pkg::STATUS_NORMAL) ||
                              ({1'b0, status_raw} == pfcc_pkg::STATUS_STALE));

    // Scale: (counts - 1000) * span; the * 100 / 14000 that follows is an exact / 140
    assign diff    = $signed({1'b0, rawp}) - 15'sd1000;
    assign span    = $signed({2'b00, pmax_reg}) - $signed({{4{pmin_reg[7]}}, pmin_reg});
    assign diff_w  = diff;
    assign span_w  = span;

    // Divide the magnitude by reciprocal multiplication, truncate toward zero
    assign prod1_mag  = prod1_reg[26] ? (27'd0 - prod1_reg) : prod1_reg;
    assign q_meas_mag = prod2_reg[49:32];
    assign q_meas     = p_neg_reg ? (26'sd0 - $signed({8'd0, q_meas_mag}))
                                  : $signed({8'd0, q_meas_mag});

    // The divider only forms the calibration average
    assign div_dividend = 32'(sum_reg);
    assign div_divisor  = pfcc_pkg::DIVISOR_W'(cnt_reg);

    pfcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quot),
        .done     (div_done)
    );

    // Add span base, remove zero offset, clamp to int16
    assign pmin_w = pmin_reg;
    assign zero_w = zero_reg;
    assign p_sum  = q_meas + pmin_w * 26'sd100 - zero_w;

    always_comb
    begin
        if (p_sum > 26'sd32767)
            p_sat = 16'sh7FFF;
        else if (p_sum < -26'sd32768)
            p_sat = -16'sh8000;
        else
            p_sat = p_sum[15:0];
    end

    // Averages beyond +/-300 centi-psi fall back to zero
    assign avg_sel = ((quot < -25'sd300) || (quot > 25'sd300)) ? 16'sd0 : quot[15:0];

    // Temperature: counts * 2000 / 2048 - 500
    assign t_scaled = 22'(rawt) * 22'd2000;
    assign tcdeg    = {1'b0, t_scaled[21:11]} - 12'd500;

    always_comb
    begin
        zero_next  = zero_reg;
        saved_next = saved_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        cal_next   = cal_reg;
        if (ctl.write)
        begin
            case (c_cmd_reg)
                pfcc_pkg::CMD_MEASURE:
                begin
                    if (!c_fault_reg && cal_reg && ok && (cnt_reg < pfcc_pkg::MAX_CAL_SAMPLES))
                    begin
                        sum_next = sum_reg + 24'(post_val_reg);
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
                pfcc_pkg::CMD_CAL_START:
                begin
                    // Keep the pre-calibration offset across repeated starts
                    if (!cal_reg)
                        saved_next = zero_reg;
                    zero_next = '0;
                    sum_next  = '0;
                    cnt_next  = '0;
                    cal_next  = 1'b1;
                end
                pfcc_pkg::CMD_CAL_FINISH:
                begin
                    if (cal_reg)
                    begin
                        zero_next = (cnt_reg == 8'd0) ? saved_reg : post_val_reg;
                        cal_next  = 1'b0;
                    end
                end
                pfcc_pkg::CMD_LOAD_DEFAULT:
                begin
                    zero_next = dflt_reg;
                    cal_next  = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg  <= '0;
            saved_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            cal_reg   <= 1'b0;
        end
        else
        begin
            zero_reg  <= zero_next;
            saved_reg <= saved_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            cal_reg   <= cal_next;
        end
    end

    assign o_status = !is_measure ? 3'd0
                    : (c_fault_reg ? pfcc_pkg::STATUS_BUS_FAULT : {1'b0, status_raw});

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.write)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            out_data_reg <= {7'd0,
                             zero_next,
                             meas_good ? tcdeg : 12'd0,
                             meas_good ? post_val_reg : 16'sd0,
                             meas_good ? rawt : 11'd0,
                             meas_good ? rawp : 14'd0,
                             ok,
                             o_status};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.meas_path = meas_good;
    assign sts.avg_path  = (c_cmd_reg == pfcc_pkg::CMD_CAL_FINISH) && cal_reg && (cnt_reg != 8'd0);
    assign sts.div_done  = div_done;
    assign sts.out_free  = out_free;

endmodule

/* rtl/pfcc_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences capture, multiply, divide, finish and result write.
module pfcc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pfcc_pkg::dp_status_t  sts,
    output pfcc_pkg::ctrl_cmd_t   ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL1,
        S_MUL2,
        S_DIV_START,
        S_DIV_WAIT,
        S_POST,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (sts.meas_path)
                    state_next = S_MUL1;
                else if (sts.avg_path)
                    state_next = S_DIV_START;
                else
                    state_next = S_WRITE;
            end
            S_MUL1:      state_next = S_MUL2;
            S_MUL2:      state_next = S_POST;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:  if (sts.div_done) state_next = S_POST;
            S_POST:      state_next = S_WRITE;
            S_WRITE:     if (sts.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign ctl.load      = (state_reg == S_IDLE) && in_valid;
    assign ctl.mul1      = (state_reg == S_MUL1);
    assign ctl.mul2      = (state_reg == S_MUL2);
    assign ctl.div_start = (state_reg == S_DIV_START);
    assign ctl.post      = (state_reg == S_POST);
    // Hold the result until the output register has room
    assign ctl.write     = (state_reg == S_WRITE) && sts.out_free;

endmodule
